FILE: design/luf_pkg.sv
// luf_pkg: shared types and constants for the list union-find engine
// used by luf_ctrl, luf_datapath and list_union_find_kruskal
`timescale 1ns / 1ps
package luf_pkg;

  localparam int CITY_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int WSUM_W  = 26;
  localparam int EWGT_W  = 16;
  localparam int ACT_W   = 3;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_SAT = 11'd2047;
  localparam logic [WSUM_W-1:0] WSUM_SAT = 26'h3FF_FFFF;
  localparam logic [SIZE_W-1:0] CITY_COUNT_RST = 11'd1024;
  localparam logic [PADDR_W-1:0] ADDR_CITY_COUNT = 2'd0;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 3'd0,
    ACT_EDGE = 3'd1,
    ACT_CMP  = 3'd2,
    ACT_SIZE = 3'd3,
    ACT_WSUM = 3'd4,
    ACT_KTH  = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_RA,
    ST_CAPA,
    ST_SETA,
    ST_RB,
    ST_CAPB,
    ST_SETB,
    ST_DECIDE,
    ST_WSTART,
    ST_WALK,
    ST_LINK,
    ST_KWALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic wr_add;
    logic rd_lead;
    logic lead_sel_b;
    logic cap_la;
    logic cap_lb;
    logic rd_set;
    logic cap_sa;
    logic cap_sb;
    logic cap_win;
    logic walk_start_lose;
    logic walk_start_la;
    logic walk_step;
    logic merge_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic same_set;
    logic cur_ok;
    logic cnt_lt_max;
    logic cnt_lt_k;
    logic out_free;
  } status_t;

endpackage

FILE: design/luf_ctrl.sv
// luf_ctrl: sequencer for the list union-find engine
// depends on luf_pkg; drives luf_datapath through cmd_t, reads status_t
`timescale 1ns / 1ps
module luf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  luf_pkg::status_t status,
  output luf_pkg::cmd_t    cmd
);
  import luf_pkg::*;

  state_t state, state_next;
  logic   post, post_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      post  <= 1'b0;
    end else begin
      state <= state_next;
      post  <= post_next;
    end
  end

  always_comb begin
    state_next = state;
    post_next  = post;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          post_next   = 1'b0;
          state_next  = ST_RA;
        end
      end
      ST_ADD: begin
        cmd.wr_add = 1'b1;
        state_next = ST_RA;
      end
      ST_RA: begin
        case (status.act) inside
          ACT_ADD: begin
            if (post) begin
              cmd.rd_lead = 1'b1;
              state_next  = ST_CAPA;
            end else begin
              post_next  = 1'b1;
              state_next = ST_ADD;
            end
          end
          ACT_EDGE, ACT_CMP, ACT_SIZE, ACT_WSUM, ACT_KTH: begin
            cmd.rd_lead = 1'b1;
            state_next  = ST_CAPA;
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_CAPA: begin
        cmd.cap_la = 1'b1;
        cmd.rd_set = 1'b1;
        state_next = ST_SETA;
      end
      ST_SETA: begin
        cmd.cap_sa = 1'b1;
        if (post) begin
          state_next = ST_FIN;
        end else begin
          case (status.act) inside
            ACT_EDGE, ACT_CMP: state_next = ST_RB;
            ACT_KTH: begin
              cmd.walk_start_la = 1'b1;
              state_next        = ST_KWALK;
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_RB: begin
        cmd.rd_lead    = 1'b1;
        cmd.lead_sel_b = 1'b1;
        state_next     = ST_CAPB;
      end
      ST_CAPB: begin
        cmd.cap_lb = 1'b1;
        cmd.rd_set = 1'b1;
        state_next = ST_SETB;
      end
      ST_SETB: begin
        cmd.cap_sb = 1'b1;
        if (status.act == ACT_EDGE && !status.same_set) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DECIDE: begin
        cmd.cap_win = 1'b1;
        state_next  = ST_WSTART;
      end
      ST_WSTART: begin
        cmd.walk_start_lose = 1'b1;
        state_next          = ST_WALK;
      end
      ST_WALK: begin
        if (status.cur_ok && status.cnt_lt_max) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.merge_wr = 1'b1;
        post_next    = 1'b1;
        state_next   = ST_RA;
      end
      ST_KWALK: begin
        if (status.cur_ok && status.cnt_lt_k) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: design/luf_datapath.sv
// luf_datapath: member memories, set registers, list walker and result register
// depends on luf_pkg; commanded by luf_ctrl
`timescale 1ns / 1ps
module luf_datapath #(
  parameter int MAX_CITIES  = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  luf_pkg::cmd_t                  cmd,
  output luf_pkg::status_t               status,
  input  logic [luf_pkg::ACT_W-1:0]      action,
  input  logic [luf_pkg::CITY_W-1:0]     city_a,
  input  logic [luf_pkg::CITY_W-1:0]     city_b,
  input  logic [luf_pkg::EWGT_W-1:0]     edge_weight,
  input  logic [luf_pkg::CITY_W-1:0]     rank_k,
  input  logic [luf_pkg::SIZE_W-1:0]     city_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ok_flag,
  output logic [luf_pkg::CITY_W-1:0]     leader_first,
  output logic [luf_pkg::CITY_W-1:0]     leader_second,
  output logic [luf_pkg::SIZE_W-1:0]     set_size,
  output logic [luf_pkg::WSUM_W-1:0]     weight_sum,
  output logic [luf_pkg::CITY_W-1:0]     member_city,
  output logic                           tree_complete
);
  import luf_pkg::*;

  localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int NW = AW + 1;
  localparam int KW = (NW > CITY_W) ? NW : CITY_W;
  localparam int RW = 2 * CITY_W + 1;

  function automatic logic [AW-1:0] reduce_city(input logic [CITY_W-1:0] x);
    logic [RW-1:0] v;
    v = RW'(x);
    if (MAX_CITIES < (1 << CITY_W)) begin
      for (int j = CITY_W - 1; j >= 0; j--) begin
        if (v >= (RW'(MAX_CITIES) << j)) v = v - (RW'(MAX_CITIES) << j);
      end
    end
    return AW'(v);
  endfunction

  function automatic logic [CITY_W-1:0] to_city(input logic [AW-1:0] x);
    logic [KW-1:0] t;
    t = KW'(x);
    return t[CITY_W-1:0];
  endfunction

  function automatic logic [EWGT_W-1:0] weight_mask();
    logic [EWGT_W-1:0] m;
    for (int i = 0; i < EWGT_W; i++) m[i] = (i < WEIGHT_BITS);
    return m;
  endfunction

  logic [AW-1:0] leader_mem [MAX_CITIES];
  logic [NW-1:0] next_mem   [MAX_CITIES];
  logic [AW-1:0] tail_mem   [MAX_CITIES];
  logic [SIZE_W-1:0] size_mem [MAX_CITIES];
  logic [WSUM_W-1:0] wsum_mem [MAX_CITIES];

  logic [AW-1:0]     lead_rd, tail_rd;
  logic [NW-1:0]     next_rd;
  logic [SIZE_W-1:0] size_rd;
  logic [WSUM_W-1:0] wsum_rd;

  act_t              act_q;
  logic [AW-1:0]     a_q, b_q;
  logic [EWGT_W-1:0] w_q;
  logic [CITY_W-1:0] k_q;
  logic [AW-1:0]     la, lb, ta, tb;
  logic [SIZE_W-1:0] sa, sb;
  logic [WSUM_W-1:0] wa, wb;
  logic [AW-1:0]     win, lose, tail_win, tail_lose;
  logic [SIZE_W-1:0] size_new;
  logic [WSUM_W-1:0] wsum_new;
  logic [NW-1:0]     cur, cur_eff, cnt;
  logic              chain, okm;
  logic [SIZE_W-1:0] tree_edges;

  logic              a_wins;
  logic [SIZE_W:0]   size_sum;
  logic [WSUM_W+1:0] wsum_sum;
  logic              cur_ok;
  logic [KW-1:0]     cnt_ext, k_ext;

  function automatic logic chain_is_kth();
    return act_q == ACT_KTH;
  endfunction

  assign cur_eff  = chain ? next_rd : cur;
  assign cur_ok   = cur_eff < NW'(MAX_CITIES);
  assign cnt_ext  = KW'(cnt);
  assign k_ext    = KW'(k_q);
  assign a_wins   = (sa != sb) ? (sa > sb) : (la < lb);
  assign size_sum = a_wins ? ({1'b0, sa} + {1'b0, sb}) : ({1'b0, sb} + {1'b0, sa});
  assign wsum_sum = (WSUM_W+2)'(wa) + (WSUM_W+2)'(wb) + (WSUM_W+2)'(w_q);

  assign status.act        = act_q;
  assign status.same_set   = (la == lb);
  assign status.cur_ok     = cur_ok;
  assign status.cnt_lt_max = cnt < NW'(MAX_CITIES);
  assign status.cnt_lt_k   = cnt_ext < k_ext;
  assign status.out_free   = !out_valid || out_ready;

  // leader memory
  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      leader_mem[a_q] <= a_q;
    end else if (cmd.walk_step && !chain_is_kth()) begin
      leader_mem[cur_eff[AW-1:0]] <= win;
    end
    if (cmd.rd_lead) lead_rd <= leader_mem[cmd.lead_sel_b ? b_q : a_q];
  end

  // next pointer memory
  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      next_mem[a_q] <= NW'(MAX_CITIES);
    end else if (cmd.merge_wr) begin
      next_mem[tail_win] <= NW'(lose);
    end
    if (cmd.walk_step) next_rd <= next_mem[cur_eff[AW-1:0]];
  end

  // per-set memories, indexed by leader
  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      tail_mem[a_q] <= a_q;
      size_mem[a_q] <= SIZE_W'(1);
      wsum_mem[a_q] <= '0;
    end else if (cmd.merge_wr) begin
      tail_mem[win] <= tail_lose;
      size_mem[win] <= size_new;
      wsum_mem[win] <= wsum_new;
    end
    if (cmd.rd_set) begin
      tail_rd <= tail_mem[lead_rd];
      size_rd <= size_mem[lead_rd];
      wsum_rd <= wsum_mem[lead_rd];
    end
  end

  // item and set registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q <= act_t'(action);
      a_q   <= reduce_city(city_a);
      b_q   <= reduce_city(city_b);
      w_q   <= edge_weight & weight_mask();
      k_q   <= rank_k;
    end
    if (cmd.cap_la) la <= lead_rd;
    if (cmd.cap_lb) lb <= lead_rd;
    if (cmd.cap_sa) begin
      sa <= size_rd;
      wa <= wsum_rd;
      ta <= tail_rd;
    end
    if (cmd.cap_sb) begin
      sb <= size_rd;
      wb <= wsum_rd;
      tb <= tail_rd;
    end
    if (cmd.cap_win) begin
      win       <= a_wins ? la : lb;
      lose      <= a_wins ? lb : la;
      tail_win  <= a_wins ? ta : tb;
      tail_lose <= a_wins ? tb : ta;
      size_new  <= (size_sum > (SIZE_W+1)'(SIZE_SAT)) ? SIZE_SAT : size_sum[SIZE_W-1:0];
      wsum_new  <= (wsum_sum > (WSUM_W+2)'(WSUM_SAT)) ? WSUM_SAT : wsum_sum[WSUM_W-1:0];
    end
    if (cmd.walk_start_lose) begin
      cur <= NW'(lose);
    end else if (cmd.walk_start_la) begin
      cur <= NW'(la);
    end else begin
      cur <= cur_eff;
    end
  end

  // walker and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= 1'b0;
      cnt        <= '0;
      okm        <= 1'b0;
      tree_edges <= '0;
    end else begin
      chain <= cmd.walk_step;
      if (cmd.walk_start_lose || cmd.walk_start_la) begin
        cnt <= '0;
      end else if (cmd.walk_step) begin
        cnt <= cnt + NW'(1);
      end
      if (cmd.load_in) begin
        okm <= 1'b0;
      end else if (cmd.merge_wr) begin
        okm <= 1'b1;
      end
      if (cmd.merge_wr && tree_edges != SIZE_SAT) tree_edges <= tree_edges + SIZE_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tree_complete <= ({1'b0, tree_edges} + (SIZE_W+1)'(1)) >= {1'b0, city_count};
      ok_flag       <= 1'b0;
      leader_first  <= '0;
      leader_second <= '0;
      set_size      <= '0;
      weight_sum    <= '0;
      member_city   <= '0;
      case (act_q) inside
        ACT_ADD, ACT_EDGE, ACT_CMP, ACT_SIZE, ACT_WSUM, ACT_KTH: begin
          leader_first <= to_city(la);
          set_size     <= sa;
          weight_sum   <= wa;
          if (act_q == ACT_EDGE) ok_flag <= okm;
          if (act_q == ACT_CMP) begin
            ok_flag       <= (la == lb);
            leader_second <= to_city(lb);
          end
          if (act_q == ACT_KTH && cur_ok) begin
            ok_flag     <= 1'b1;
            member_city <= to_city(cur_eff[AW-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> cur_ok) else $error("walk step past end of list");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_edges_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_wr && tree_edges != SIZE_SAT |=> tree_edges == $past(tree_edges) + SIZE_W'(1))
    else $error("tree edge count not raised");
`endif

endmodule

FILE: design/list_union_find_kruskal.sv
// list_union_find_kruskal: top level of the list union-find engine
// depends on luf_pkg, luf_ctrl and luf_datapath
`timescale 1ns / 1ps
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-----------------
//  input    | action city_a city_b edge_weight rank_k  | in_valid/in_ready
//  result   | ok_flag leader_* set_size weight_sum ... | out_valid/out_ready
//  config   | psel penable pwrite paddr pwdata prdata  | pready tied high
//
//  from the input transfer to the result: add writes a new singleton first;
//  every known action reads city_a's leader and set, compare and edge also
//  city_b's; an unknown action goes straight to the result; a merge walks
//  each member of the smaller set, a kth query up to rank_k list steps
//  reset clears control and city_count; member memories start unwritten
//  one item at a time, ready again the cycle after the result is loaded;
//  a held result stalls only the final cycle
module list_union_find_kruskal #(
  parameter int MAX_CITIES  = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [luf_pkg::ACT_W-1:0]       action,
  input  logic [luf_pkg::CITY_W-1:0]      city_a,
  input  logic [luf_pkg::CITY_W-1:0]      city_b,
  input  logic [luf_pkg::EWGT_W-1:0]      edge_weight,
  input  logic [luf_pkg::CITY_W-1:0]      rank_k,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok_flag,
  output logic [luf_pkg::CITY_W-1:0]      leader_first,
  output logic [luf_pkg::CITY_W-1:0]      leader_second,
  output logic [luf_pkg::SIZE_W-1:0]      set_size,
  output logic [luf_pkg::WSUM_W-1:0]      weight_sum,
  output logic [luf_pkg::CITY_W-1:0]      member_city,
  output logic                            tree_complete,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [luf_pkg::PADDR_W-1:0]     paddr,
  input  logic [luf_pkg::PDATA_W-1:0]     pwdata,
  output logic [luf_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import luf_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [SIZE_W-1:0] city_count;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CITY_COUNT) ? PDATA_W'(city_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CITY_COUNT) begin
      city_count <= pwdata[SIZE_W-1:0];
    end
  end

  luf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  luf_datapath #(
    .MAX_CITIES  (MAX_CITIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (action),
    .city_a        (city_a),
    .city_b        (city_b),
    .edge_weight   (edge_weight),
    .rank_k        (rank_k),
    .city_count    (city_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok_flag       (ok_flag),
    .leader_first  (leader_first),
    .leader_second (leader_second),
    .set_size      (set_size),
    .weight_sum    (weight_sum),
    .member_city   (member_city),
    .tree_complete (tree_complete)
  );

endmodule
